### hw/rtl/kway_sorted_merge_macros.svh
// Assertion macros shared by the merge checker
`ifndef KWAY_SORTED_MERGE_MACROS_SVH
`define KWAY_SORTED_MERGE_MACROS_SVH

// same-cycle implication
`define KWSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwsm same-cycle check failed");

// next-cycle implication
`define KWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwsm next-cycle check failed");

`endif

### hw/rtl/kwsm_pkg.sv
// Shared constants and types for the k-way sorted merge
package kwsm_pkg;

  localparam int MAX_LISTS_DEF = 8;
  localparam int ELEM_BITS_DEF = 32;
  localparam int LIST_ID_W     = 3;
  localparam int CFG_W         = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic clr;
    logic rm;
    logic ins;
  } cell_ctl_t;

endpackage

### hw/rtl/kwsm_cell.sv
// One slot of the sorted head row: holds one pending head and its list id
module kwsm_cell #(
  parameter int ELEM_BITS = kwsm_pkg::ELEM_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kwsm_pkg::cell_ctl_t                  ctl_i,
  input  logic [kwsm_pkg::CFG_W-1:0]           cfg_n_i,
  input  logic signed [ELEM_BITS-1:0]          new_val_i,
  input  logic [kwsm_pkg::LIST_ID_W-1:0]       new_id_i,
  input  logic                                 prev_vld_i,
  input  logic signed [ELEM_BITS-1:0]          prev_val_i,
  input  logic [kwsm_pkg::LIST_ID_W-1:0]       prev_id_i,
  input  logic                                 prev_shl_i,
  input  logic                                 prev_ltl_i,
  input  logic                                 next_vld_i,
  input  logic signed [ELEM_BITS-1:0]          next_val_i,
  input  logic [kwsm_pkg::LIST_ID_W-1:0]       next_id_i,
  input  logic                                 next_lt_i,
  input  logic                                 seen_i,
  input  logic signed [ELEM_BITS-1:0]          pick_val_i,
  input  logic [kwsm_pkg::LIST_ID_W-1:0]       pick_id_i,
  input  logic                                 below_i,
  output logic                                 vld_o,
  output logic signed [ELEM_BITS-1:0]          val_o,
  output logic [kwsm_pkg::LIST_ID_W-1:0]       id_o,
  output logic                                 lt_o,
  output logic                                 shl_o,
  output logic                                 ltl_o,
  output logic                                 seen_o,
  output logic signed [ELEM_BITS-1:0]          pick_val_o,
  output logic [kwsm_pkg::LIST_ID_W-1:0]       pick_id_o,
  output logic                                 below_o
);
  import kwsm_pkg::*;

  logic                        vld_q, vld_d;
  logic signed [ELEM_BITS-1:0] val_q, val_d;
  logic [LIST_ID_W-1:0]        id_q, id_d;
  logic                        act, sel, lt, shl, ltl;

  always_comb begin
    lt  = vld_q && ((val_q < new_val_i) || ((val_q == new_val_i) && (id_q < new_id_i)));
    act = vld_q && ((id_q == '0) || (CFG_W'(id_q) < cfg_n_i));
    sel = act && !seen_i;
    shl = ctl_i.rm && (seen_i || act);
    ltl = shl ? next_lt_i : lt;
  end

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    id_d  = id_q;
    if (shl) begin
      vld_d = next_vld_i;
      val_d = next_val_i;
      id_d  = next_id_i;
    end
    if (ctl_i.ins && !ltl) begin
      if (prev_ltl_i) begin
        vld_d = 1'b1;
        val_d = new_val_i;
        id_d  = new_id_i;
      end else if (prev_shl_i) begin
        vld_d = vld_q;
        val_d = val_q;
        id_d  = id_q;
      end else begin
        vld_d = prev_vld_i;
        val_d = prev_val_i;
        id_d  = prev_id_i;
      end
    end
    if (ctl_i.clr) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    id_q  <= id_d;
  end

  assign vld_o      = vld_q;
  assign val_o      = val_q;
  assign id_o       = id_q;
  assign lt_o       = lt;
  assign shl_o      = shl;
  assign ltl_o      = ltl;
  assign seen_o     = seen_i || act;
  assign pick_val_o = sel ? val_q : pick_val_i;
  assign pick_id_o  = sel ? id_q : pick_id_i;
  assign below_o    = below_i || (act && lt);

endmodule

### hw/rtl/kwsm_outbuf.sv
// Output register with a skid stage for result words
module kwsm_outbuf #(
  parameter int W = 36
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         stall_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic         full_o
);

  logic         out_vld_q, out_vld_d;
  logic [W-1:0] out_dat_q, out_dat_d;
  logic         skd_vld_q, skd_vld_d;
  logic [W-1:0] skd_dat_q, skd_dat_d;
  logic         drain;

  always_comb begin
    drain     = out_vld_q && !stall_i;
    out_vld_d = out_vld_q;
    out_dat_d = out_dat_q;
    skd_vld_d = skd_vld_q;
    skd_dat_d = skd_dat_q;
    if (skd_vld_q) begin
      if (drain) begin
        out_dat_d = skd_dat_q;
        skd_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || drain) begin
        out_vld_d = 1'b1;
        out_dat_d = data_i;
      end else begin
        skd_vld_d = 1'b1;
        skd_dat_d = data_i;
      end
    end else if (drain) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q <= out_dat_d;
    skd_dat_q <= skd_dat_d;
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_dat_q;
  assign full_o  = skd_vld_q;

endmodule

### hw/rtl/kway_sorted_merge.sv
// K-way sorted merge: a sorted row of head cells with per-list flags
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | list_id_i, has_value_i, elem_value_i
//   out     | output    | out_valid_o / out_stall_i | out_value_o, source_list_o, all_done_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | active_lists_i
//
// One input word per cycle while in_stall_o is low; results are registered in the
// output or skid register. Insert and select resolve combinationally across the row.
// Reset clears list flags and all valid bits, and sets the active list count to 8.
// in_stall_o rises only while the output register and its skid stage are full.
module kway_sorted_merge #(
  parameter int MAX_LISTS = kwsm_pkg::MAX_LISTS_DEF,
  parameter int ELEM_BITS = kwsm_pkg::ELEM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kwsm_pkg::CFG_W-1:0]      active_lists_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kwsm_pkg::LIST_ID_W-1:0]  list_id_i,
  input  logic                            has_value_i,
  input  logic signed [ELEM_BITS-1:0]     elem_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ELEM_BITS-1:0]     out_value_o,
  output logic [kwsm_pkg::LIST_ID_W-1:0]  source_list_o,
  output logic                            all_done_o
);
  import kwsm_pkg::*;

  localparam int OW = ELEM_BITS + LIST_ID_W + 1;

  logic [CFG_W-1:0]     active_q;
  logic [MAX_LISTS-1:0] pres_q, pres_d, fin_q, fin_d;
  logic [MAX_LISTS-1:0] act_mask, hit, src_hit, pres_upd, fin_upd;
  logic                 fire, legal, ins, endm, ready, all_end, found, new_sel;
  logic                 emit_sel, push, full;
  logic signed [ELEM_BITS-1:0] res_val;
  logic [LIST_ID_W-1:0] res_id;
  logic [OW-1:0]        push_dat, out_dat;
  cell_ctl_t            ctl;

  logic                        c_vld [MAX_LISTS];
  logic signed [ELEM_BITS-1:0] c_val [MAX_LISTS];
  logic [LIST_ID_W-1:0]        c_id  [MAX_LISTS];
  logic                        c_lt  [MAX_LISTS];
  logic                        c_shl [MAX_LISTS];
  logic                        c_ltl [MAX_LISTS];
  logic                        ch_seen  [MAX_LISTS+1];
  logic signed [ELEM_BITS-1:0] ch_pval  [MAX_LISTS+1];
  logic [LIST_ID_W-1:0]        ch_pid   [MAX_LISTS+1];
  logic                        ch_below [MAX_LISTS+1];

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= active_lists_i;
    end
  end

  assign ch_seen[0]  = 1'b0;
  assign ch_pval[0]  = '0;
  assign ch_pid[0]   = '0;
  assign ch_below[0] = 1'b0;

  for (genvar j = 0; j < MAX_LISTS; j++) begin : g_cell
    logic                        pv, pshl, pltl, nv, nlt;
    logic signed [ELEM_BITS-1:0] pval, nval;
    logic [LIST_ID_W-1:0]        pid, nid;

    if (j == 0) begin : g_head
      assign pv   = 1'b0;
      assign pval = '0;
      assign pid  = '0;
      assign pshl = 1'b0;
      assign pltl = 1'b1;
    end else begin : g_left
      assign pv   = c_vld[j-1];
      assign pval = c_val[j-1];
      assign pid  = c_id[j-1];
      assign pshl = c_shl[j-1];
      assign pltl = c_ltl[j-1];
    end

    if (j == MAX_LISTS - 1) begin : g_tail
      assign nv   = 1'b0;
      assign nval = '0;
      assign nid  = '0;
      assign nlt  = 1'b0;
    end else begin : g_right
      assign nv   = c_vld[j+1];
      assign nval = c_val[j+1];
      assign nid  = c_id[j+1];
      assign nlt  = c_lt[j+1];
    end

    kwsm_cell #(
      .ELEM_BITS (ELEM_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cfg_n_i    (active_q),
      .new_val_i  (elem_value_i),
      .new_id_i   (list_id_i),
      .prev_vld_i (pv),
      .prev_val_i (pval),
      .prev_id_i  (pid),
      .prev_shl_i (pshl),
      .prev_ltl_i (pltl),
      .next_vld_i (nv),
      .next_val_i (nval),
      .next_id_i  (nid),
      .next_lt_i  (nlt),
      .seen_i     (ch_seen[j]),
      .pick_val_i (ch_pval[j]),
      .pick_id_i  (ch_pid[j]),
      .below_i    (ch_below[j]),
      .vld_o      (c_vld[j]),
      .val_o      (c_val[j]),
      .id_o       (c_id[j]),
      .lt_o       (c_lt[j]),
      .shl_o      (c_shl[j]),
      .ltl_o      (c_ltl[j]),
      .seen_o     (ch_seen[j+1]),
      .pick_val_o (ch_pval[j+1]),
      .pick_id_o  (ch_pid[j+1]),
      .below_o    (ch_below[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      act_mask[i] = (i == 0) || (i < int'(active_q));
      hit[i]      = (int'(list_id_i) == i) && act_mask[i];
    end
    legal    = |(hit & ~pres_q & ~fin_q);
    ins      = fire && legal && has_value_i;
    endm     = fire && legal && !has_value_i;
    pres_upd = pres_q | (ins ? hit : '0);
    fin_upd  = fin_q | (endm ? hit : '0);
    ready    = &(pres_upd | fin_upd | ~act_mask);
    all_end  = &(fin_upd | ~act_mask);
    found    = ins || ch_seen[MAX_LISTS];
    new_sel  = ins && !ch_below[MAX_LISTS];
    emit_sel = fire && !all_end && ready && found;
    res_val  = new_sel ? elem_value_i : ch_pval[MAX_LISTS];
    res_id   = new_sel ? list_id_i : ch_pid[MAX_LISTS];
    for (int i = 0; i < MAX_LISTS; i++) begin
      src_hit[i] = (int'(res_id) == i);
    end
    ctl.clr = fire && all_end;
    ctl.rm  = emit_sel && !new_sel;
    ctl.ins = ins && !(emit_sel && new_sel);
    push    = fire && (all_end || emit_sel);
    if (all_end) begin
      push_dat = {1'b1, LIST_ID_W'(0), ELEM_BITS'(0)};
    end else begin
      push_dat = {1'b0, res_id, res_val};
    end
    pres_d = pres_q;
    fin_d  = fin_q;
    if (fire) begin
      if (all_end) begin
        pres_d = '0;
        fin_d  = '0;
      end else begin
        pres_d = emit_sel ? (pres_upd & ~src_hit) : pres_upd;
        fin_d  = fin_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= '0;
      fin_q  <= '0;
    end else begin
      pres_q <= pres_d;
      fin_q  <= fin_d;
    end
  end

  kwsm_outbuf #(
    .W (OW)
  ) u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_dat),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_dat),
    .full_o  (full)
  );

  assign in_stall_o    = full;
  assign out_value_o   = out_dat[ELEM_BITS-1:0];
  assign source_list_o = out_dat[ELEM_BITS +: LIST_ID_W];
  assign all_done_o    = out_dat[OW-1];

endmodule

### hw/rtl/kwsm_checker.sv
// Port-level checker for the k-way sorted merge, bound to the top level
`include "kway_sorted_merge_macros.svh"

module kwsm_checker #(
  parameter int ELEM_BITS = kwsm_pkg::ELEM_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [ELEM_BITS-1:0]    out_value_o,
  input logic [kwsm_pkg::LIST_ID_W-1:0] source_list_o,
  input logic                           all_done_o
);

  `KWSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_value_o) && $stable(source_list_o) && $stable(all_done_o))

  `KWSM_ASSERT_IMPLY(a_done_zero, clk_i, rst_ni, out_valid_o && all_done_o,
    (out_value_o == '0) && (source_list_o == '0))

  `KWSM_ASSERT_IMPLY(a_stall_backed, clk_i, rst_ni, in_stall_o, out_valid_o)

  `KWSM_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o),
    $past(out_valid_o && out_stall_i))

endmodule

bind kway_sorted_merge kwsm_checker #(
  .ELEM_BITS (ELEM_BITS)
) u_kwsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_value_o   (out_value_o),
  .source_list_o (source_list_o),
  .all_done_o    (all_done_o)
);
